// File: rtl/afp_pkg.sv
// Shared transfer types for the anemometer frame parser.
package afp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       maintenance_switch;
		logic       rotor_turning;
	} in_t;

	typedef struct packed {
		logic        [7:0]  frame_address;
		logic        [7:0]  frame_status;
		logic signed [15:0] wind_u;
		logic signed [15:0] wind_v;
		logic signed [15:0] wind_w;
		logic signed [15:0] temperature_raw;
	} out_t;

endpackage

// File: rtl/afp_frame_fsm.sv
// Byte phase machine: sync hunt, payload capture, checksum check.
module afp_frame_fsm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  afp_pkg::in_t  item,
	output logic          hit,
	output afp_pkg::out_t frame
);
	import afp_pkg::*;

	localparam logic [3:0] PH_HUNT   = 4'd0;
	localparam logic [3:0] PH_SYNC   = 4'd1;
	localparam logic [3:0] PH_ADDR   = 4'd2;
	localparam logic [3:0] PH_STAT   = 4'd3;
	localparam logic [3:0] PH_U_HI   = 4'd4;
	localparam logic [3:0] PH_U_LO   = 4'd5;
	localparam logic [3:0] PH_V_HI   = 4'd6;
	localparam logic [3:0] PH_V_LO   = 4'd7;
	localparam logic [3:0] PH_W_HI   = 4'd8;
	localparam logic [3:0] PH_W_LO   = 4'd9;
	localparam logic [3:0] PH_T_HI   = 4'd10;
	localparam logic [3:0] PH_T_LO   = 4'd11;
	localparam logic [3:0] PH_CSUM   = 4'd12;

	localparam logic [7:0] SYNC_BYTE     = 8'hBA;
	localparam logic [7:0] MERGE_ADDRESS = 8'h06;
	localparam logic [7:0] MAINT_BIT     = 8'h08;
	localparam logic [7:0] TURN_BIT      = 8'h10;

	logic [3:0]  phase_q;
	logic [7:0]  xor_q;
	logic [7:0]  addr_q;
	logic [7:0]  stat_q;
	logic [15:0] u_q;
	logic [15:0] v_q;
	logic [15:0] w_q;
	logic [15:0] t_q;
	logic [7:0]  b;
	logic [7:0]  stat_merged;

	assign b = item.data_byte;

	always_comb begin
		stat_merged = b;
		if (addr_q == MERGE_ADDRESS) begin
			if (item.maintenance_switch) stat_merged = stat_merged | MAINT_BIT;
			if (item.rotor_turning) stat_merged = stat_merged | TURN_BIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else if (step) begin
			case (phase_q)
				PH_HUNT: begin
					if (b == SYNC_BYTE) phase_q <= PH_SYNC;
				end
				PH_SYNC: begin
					phase_q <= (b == SYNC_BYTE) ? PH_ADDR : PH_HUNT;
				end
				PH_ADDR, PH_STAT, PH_U_HI, PH_U_LO, PH_V_HI, PH_V_LO,
				PH_W_HI, PH_W_LO, PH_T_HI, PH_T_LO: begin
					phase_q <= phase_q + 4'd1;
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	// Capture registers carry no reset: they are always written before a frame reaches
	// the checksum phase.
	always_ff @(posedge clk) begin
		if (step) begin
			case (phase_q)
				PH_SYNC: xor_q <= 8'h00;
				PH_ADDR: begin xor_q <= xor_q ^ b; addr_q <= b; end
				PH_STAT: begin xor_q <= xor_q ^ b; stat_q <= stat_merged; end
				PH_U_HI: begin xor_q <= xor_q ^ b; u_q[15:8] <= b; end
				PH_U_LO: begin xor_q <= xor_q ^ b; u_q[7:0] <= b; end
				PH_V_HI: begin xor_q <= xor_q ^ b; v_q[15:8] <= b; end
				PH_V_LO: begin xor_q <= xor_q ^ b; v_q[7:0] <= b; end
				PH_W_HI: begin xor_q <= xor_q ^ b; w_q[15:8] <= b; end
				PH_W_LO: begin xor_q <= xor_q ^ b; w_q[7:0] <= b; end
				PH_T_HI: begin xor_q <= xor_q ^ b; t_q[15:8] <= b; end
				PH_T_LO: begin xor_q <= xor_q ^ b; t_q[7:0] <= b; end
				default: ;
			endcase
		end
	end

	assign hit = step && (phase_q == PH_CSUM) && (b == xor_q);

	assign frame.frame_address   = addr_q;
	assign frame.frame_status    = stat_q;
	assign frame.wind_u          = $signed(u_q);
	assign frame.wind_v          = $signed(v_q);
	assign frame.wind_w          = $signed(w_q);
	assign frame.temperature_raw = $signed(t_q);

	// The phase never leaves the range up to the checksum phase.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_CSUM)
		else $error("phase beyond checksum phase");

	// After the checksum byte the parser is hunting again, match or not.
	a_csum_returns: assert property (@(posedge clk) disable iff (!arst_n)
		step && (phase_q == PH_CSUM) |=> phase_q == PH_HUNT)
		else $error("parser did not return to hunt after checksum");

	// A broken second sync byte drops back to hunting.
	a_broken_sync: assert property (@(posedge clk) disable iff (!arst_n)
		step && (phase_q == PH_SYNC) && (b != SYNC_BYTE) |=> phase_q == PH_HUNT)
		else $error("broken sync not handled");

endmodule

// File: rtl/anemometer_frame_parser.sv
// Top level of the anemometer binary frame parser with input and output registers.
// A frame result is presented from the output register; its checksum byte passes the input
// register first, and a stall on the output side can hold it there before the output register
// loads. Throughput: one byte per cycle while the output register is not full and stalled.
// The input register stalls only while it holds a byte and the output register is full
// and stalled. Reset clears the phase machine and all valid flags asynchronously.
module anemometer_frame_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_stall,
	input  afp_pkg::in_t  byte_data,
	output logic          frame_valid,
	input  logic          frame_stall,
	output afp_pkg::out_t frame_data
);
	import afp_pkg::*;

	logic valid_s1;
	in_t  item_s1;
	logic advance;
	logic step;
	logic hit;
	out_t frame;
	logic out_valid_q;
	out_t out_q;

	// The input stage may hand its byte on whenever the output register is free or
	// its result is being transferred in this same cycle.
	assign advance    = !out_valid_q || !frame_stall;
	assign step       = valid_s1 && advance;
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) item_s1 <= byte_data;
	end

	afp_frame_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.hit    (hit),
		.frame  (frame)
	);

	// The output register loads a result when a frame passes its checksum and
	// empties when its result is transferred without a new one behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) out_q <= frame;
	end

	assign frame_valid = out_valid_q;
	assign frame_data  = out_q;

	// An empty input register never stalls the upstream side.
	a_no_empty_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !byte_stall)
		else $error("stall with empty input register");

	// A result is produced only when the output register has room for it.
	a_hit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> advance)
		else $error("result produced with output register blocked");

	// A result that passed its checksum shows up at the output in the next cycle.
	a_hit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		hit |=> frame_valid)
		else $error("result lost after checksum match");

endmodule

// File: sim/tb_anemometer_frame_parser.sv
// Self-checking testbench for the anemometer binary frame parser.
`timescale 1ns / 100ps

module tb_anemometer_frame_parser;
	import afp_pkg::*;

	// Phases of the frame hunt. The payload phases run from the address phase
	// up to the last payload phase, and the checksum byte follows them.
	localparam logic [3:0] PH_HUNT            = 4'd0;
	localparam logic [3:0] PH_SECOND_SYNC     = 4'd1;
	localparam logic [3:0] PH_ADDRESS         = 4'd2;
	localparam logic [3:0] PH_STATUS          = 4'd3;
	localparam logic [3:0] PH_U_HIGH          = 4'd4;
	localparam logic [3:0] PH_U_LOW           = 4'd5;
	localparam logic [3:0] PH_V_HIGH          = 4'd6;
	localparam logic [3:0] PH_V_LOW           = 4'd7;
	localparam logic [3:0] PH_W_HIGH          = 4'd8;
	localparam logic [3:0] PH_W_LOW           = 4'd9;
	localparam logic [3:0] PH_TEMP_HIGH       = 4'd10;
	localparam logic [3:0] LAST_PAYLOAD_PHASE = 4'd11;
	localparam logic [3:0] PH_CHECKSUM        = 4'd12;

	localparam logic [7:0] SYNC_BYTE     = 8'hBA;
	localparam logic [7:0] MERGE_ADDRESS = 8'h06;
	localparam logic [7:0] MAINT_BIT     = 8'h08;
	localparam logic [7:0] TURN_BIT      = 8'h10;

	localparam int RANDOM_BYTES   = 1300;
	localparam int IDLE_PCT       = 36;
	localparam int WATCHDOG_LIMIT = 1000;
	// A result leaves through the input and output registers after its checksum byte; allow some slack.
	localparam int DRAIN_CYCLES   = 8;
	localparam int N_DIRECTED     = 28;
	// Stretch of the random part in which neither side idles.
	localparam int BUSY_FROM      = 400;
	localparam int BUSY_TO        = 700;
	// Point in the random part where the sender waits for every result.
	localparam int PAUSE_AT       = 900;

	// One row of the directed table. When typed is set, the row carries the
	// checksum byte of the frame whose result is written out below by hand.
	typedef struct packed {
		in_t  item;
		logic typed;
	} stim_row_t;

	// Address 6 with both switches set on the status byte, and all the word
	// extremes. The checksum covers the status byte as it arrived (0x00).
	localparam out_t MERGED_EXTREMES = '{8'h06, 8'h18, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000};

	logic  clk = 1'b0;
	logic  arst_n;
	logic  byte_valid;
	logic  byte_stall;
	in_t   byte_data;
	logic  frame_valid;
	logic  frame_stall;
	out_t  frame_data;

	// Predicted parser state.
	logic [3:0]  hunt_phase = PH_HUNT;
	logic [7:0]  xor_acc    = '0;
	logic [7:0]  addr_acc   = '0;
	logic [7:0]  status_acc = '0;
	logic [15:0] u_acc      = '0;
	logic [15:0] v_acc      = '0;
	logic [15:0] w_acc      = '0;
	logic [15:0] temp_acc   = '0;

	// Frames that passed their checksum and are still owed by the block.
	out_t frames_due[$];

	int n_errors     = 0;
	int sent_bytes   = 0;
	int idle_pct     = IDLE_PCT;
	int stall_pct    = IDLE_PCT;
	int quiet_cycles = 0;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// Broken sync: a first sync byte followed by something else.
		'{'{8'hBA, 1'b1, 1'b0}, 1'b0},
		'{'{8'h00, 1'b0, 1'b1}, 1'b0},
		// A good frame at address 6. The switches on the address byte must
		// not matter; only the ones sampled with the status byte do.
		'{'{8'hBA, 1'b0, 1'b0}, 1'b0},
		'{'{8'hBA, 1'b0, 1'b0}, 1'b0},
		'{'{8'h06, 1'b1, 1'b0}, 1'b0},
		'{'{8'h00, 1'b1, 1'b1}, 1'b0},
		'{'{8'h7F, 1'b0, 1'b0}, 1'b0},
		'{'{8'hFF, 1'b0, 1'b0}, 1'b0},
		'{'{8'h80, 1'b0, 1'b0}, 1'b0},
		'{'{8'h00, 1'b0, 1'b0}, 1'b0},
		'{'{8'hFF, 1'b0, 1'b0}, 1'b0},
		'{'{8'hFF, 1'b0, 1'b0}, 1'b0},
		'{'{8'h00, 1'b0, 1'b0}, 1'b0},
		'{'{8'h00, 1'b0, 1'b0}, 1'b0},
		'{'{8'h06, 1'b0, 1'b0}, 1'b1},
		// All-ones address and status with the switches set: no merge away
		// from address 6. The checksum should be 0x01, so 0xFE drops it.
		'{'{8'hBA, 1'b1, 1'b1}, 1'b0},
		'{'{8'hBA, 1'b1, 1'b1}, 1'b0},
		'{'{8'hFF, 1'b0, 1'b1}, 1'b0},
		'{'{8'hFF, 1'b1, 1'b1}, 1'b0},
		'{'{8'h80, 1'b0, 1'b0}, 1'b0},
		'{'{8'h00, 1'b0, 1'b0}, 1'b0},
		'{'{8'h7F, 1'b0, 1'b0}, 1'b0},
		'{'{8'hFF, 1'b0, 1'b0}, 1'b0},
		'{'{8'h00, 1'b0, 1'b0}, 1'b0},
		'{'{8'h01, 1'b0, 1'b0}, 1'b0},
		'{'{8'hFF, 1'b0, 1'b0}, 1'b0},
		'{'{8'hFF, 1'b0, 1'b0}, 1'b0},
		'{'{8'hFE, 1'b1, 1'b1}, 1'b0}
	};

	anemometer_frame_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_data   (byte_data),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_data  (frame_data)
	);

	always #5 clk = ~clk;

	// Advances the predicted parser by one byte and queues a frame when the
	// checksum byte matches the XOR of the ten payload bytes.
	function automatic void parse_byte(in_t b);
		out_t       frame;
		logic [7:0] merged;
		merged = b.data_byte;
		if (hunt_phase == PH_HUNT) begin
			if (b.data_byte == SYNC_BYTE)
				hunt_phase = PH_SECOND_SYNC;
		end else if (hunt_phase == PH_SECOND_SYNC) begin
			// A byte that breaks the sync is dropped, not retried as a first sync.
			if (b.data_byte == SYNC_BYTE) begin
				hunt_phase = PH_ADDRESS;
				xor_acc = '0;
			end else begin
				hunt_phase = PH_HUNT;
			end
		end else if (hunt_phase <= LAST_PAYLOAD_PHASE) begin
			xor_acc ^= b.data_byte;
			case (hunt_phase)
				PH_ADDRESS: addr_acc = b.data_byte;
				PH_STATUS: begin
					if (addr_acc == MERGE_ADDRESS) begin
						if (b.maintenance_switch)
							merged |= MAINT_BIT;
						if (b.rotor_turning)
							merged |= TURN_BIT;
					end
					status_acc = merged;
				end
				PH_U_HIGH:          u_acc = {b.data_byte, 8'h00};
				PH_U_LOW:           u_acc[7:0] = b.data_byte;
				PH_V_HIGH:          v_acc = {b.data_byte, 8'h00};
				PH_V_LOW:           v_acc[7:0] = b.data_byte;
				PH_W_HIGH:          w_acc = {b.data_byte, 8'h00};
				PH_W_LOW:           w_acc[7:0] = b.data_byte;
				PH_TEMP_HIGH:       temp_acc = {b.data_byte, 8'h00};
				LAST_PAYLOAD_PHASE: temp_acc[7:0] = b.data_byte;
				default: ;
			endcase
			hunt_phase = hunt_phase + 4'd1;
		end else if (hunt_phase == PH_CHECKSUM) begin
			hunt_phase = PH_HUNT;
			if (b.data_byte == xor_acc) begin
				frame.frame_address   = addr_acc;
				frame.frame_status    = status_acc;
				frame.wind_u          = u_acc;
				frame.wind_v          = v_acc;
				frame.wind_w          = w_acc;
				frame.temperature_raw = temp_acc;
				frames_due.push_back(frame);
			end
		end else begin
			// Phases past the checksum cannot be reached; fall back to hunting.
			hunt_phase = PH_HUNT;
		end
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_errors++;
		end
	endfunction

	// Offers one byte, with random idle cycles ahead of it, and holds it until
	// the transfer happens. Called and returning just after a falling edge, so
	// valid and data are written at most once per time step.
	task automatic send_byte(in_t item);
		while ($urandom_range(99) < idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= item;
		do @(posedge clk); while (byte_stall);
		parse_byte(item);
		@(negedge clk);
	endtask

	// Holds the sender off until every frame owed has come out.
	task automatic wait_for_frames();
		byte_valid <= 1'b0;
		while (frames_due.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// Sends one frame with random content. Most frames are well formed; the
	// rest carry a bad checksum, a broken sync, a cut-off payload, or are
	// plain noise. A truncated frame leaves the parser mid-payload, so the
	// following sync bytes are eaten as payload, just as on a real link.
	task automatic send_random_frame();
		logic [7:0] frame_bytes [13];
		int         kind;
		int         n_send;
		kind = $urandom_range(99);
		frame_bytes[0] = SYNC_BYTE;
		frame_bytes[1] = SYNC_BYTE;
		frame_bytes[2] = ($urandom_range(2) == 0) ? MERGE_ADDRESS : 8'($urandom);
		for (int k = 3; k < 12; k++)
			frame_bytes[k] = 8'($urandom);
		frame_bytes[12] = '0;
		for (int k = 2; k < 12; k++)
			frame_bytes[12] ^= frame_bytes[k];
		n_send = 13;
		if (kind < 10) begin
			frame_bytes[12] ^= 8'($urandom_range(1, 255));
		end else if (kind < 16) begin
			frame_bytes[1] = 8'($urandom_range(0, 254));
			if (frame_bytes[1] >= SYNC_BYTE)
				frame_bytes[1]++;
			n_send = 2;
		end else if (kind < 22) begin
			n_send = $urandom_range(3, 12);
		end else if (kind < 28) begin
			n_send = $urandom_range(1, 6);
			for (int k = 0; k < n_send; k++)
				frame_bytes[k] = 8'($urandom);
		end
		for (int k = 0; k < n_send; k++)
			send_byte('{frame_bytes[k], 1'($urandom), 1'($urandom)});
		// Noise is mostly ignored by the parser, so it does not count.
		if (kind < 22 || kind >= 28)
			sent_bytes += n_send;
	endtask

	// The receiver stalls at random, except in the busy stretch.
	always @(negedge clk)
		frame_stall <= ($urandom_range(99) < stall_pct);

	// Every result transfer is checked against the oldest frame owed.
	always @(posedge clk) begin
		if (arst_n && frame_valid && !frame_stall) begin
			if (frames_due.size() == 0) begin
				$error("frame result with none expected: address %0h",
					frame_data.frame_address);
				n_errors++;
			end else begin
				out_t want;
				want = frames_due.pop_front();
				check_field("frame_address", 16'(want.frame_address),
					16'(frame_data.frame_address));
				check_field("frame_status", 16'(want.frame_status),
					16'(frame_data.frame_status));
				check_field("wind_u", want.wind_u, frame_data.wind_u);
				check_field("wind_v", want.wind_v, frame_data.wind_v);
				check_field("wind_w", want.wind_w, frame_data.wind_w);
				check_field("temperature_raw", want.temperature_raw,
					frame_data.temperature_raw);
			end
		end
	end

	// Watchdog: ends the run once no transfer has happened on either side
	// for too long.
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (frame_valid && !frame_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic paused;
		paused     = 1'b0;
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		byte_data  = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table. The typed row must leave exactly the hand-written
		// frame at the back of the queue of frames owed.
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_byte(directed_rows[i].item);
			if (directed_rows[i].typed) begin
				if (frames_due.size() == 0) begin
					$error("frame_address: expected %0h, got no frame",
						MERGED_EXTREMES.frame_address);
					n_errors++;
				end else if (frames_due[$] !== MERGED_EXTREMES) begin
					$error("frame_status: expected %0h, got %0h",
						MERGED_EXTREMES.frame_status, frames_due[$].frame_status);
					n_errors++;
				end
			end
		end
		wait_for_frames();

		// Random frames, with a stretch in which neither side idles and one
		// pause in which the sender lets every owed frame drain.
		while (sent_bytes < RANDOM_BYTES) begin
			if (sent_bytes >= BUSY_FROM && sent_bytes < BUSY_TO) begin
				idle_pct  = 0;
				stall_pct = 0;
			end else begin
				idle_pct  = IDLE_PCT;
				stall_pct = IDLE_PCT;
			end
			if (!paused && sent_bytes >= PAUSE_AT) begin
				paused = 1'b1;
				wait_for_frames();
			end
			send_random_frame();
		end
		idle_pct  = IDLE_PCT;
		stall_pct = IDLE_PCT;
		wait_for_frames();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
